// ===== rtl/qau_pkg.sv =====
// Package for the quaternion arithmetic unit: word and accumulator types,
// operation codes and fixed-point constants. Depends on nothing else.
package qau_pkg;

    localparam int DW     = 32;   // word width of every operand and result
    localparam int FB     = 28;   // fraction bits (Q3.28)
    localparam int OP_W   = DW + 1;
    localparam int P_W    = 2 * OP_W;
    localparam int ACC_W  = 72;   // wide enough for every exact sum
    localparam int NPROD  = 16;
    localparam int NLANE  = 9;

    typedef logic signed [DW-1:0]    word_t;
    typedef logic signed [OP_W-1:0]  op_t;
    typedef logic signed [P_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [3:0]              mode_t;
    typedef logic [1:0]              row_t;

    localparam mode_t MODE_ADD   = 4'd0;
    localparam mode_t MODE_SUB   = 4'd1;
    localparam mode_t MODE_MUL   = 4'd2;
    localparam mode_t MODE_SCALE = 4'd3;
    localparam mode_t MODE_NEG   = 4'd4;
    localparam mode_t MODE_CONJ  = 4'd5;
    localparam mode_t MODE_DOT   = 4'd6;
    localparam mode_t MODE_LENSQ = 4'd7;
    localparam mode_t MODE_ROT   = 4'd8;
    localparam mode_t MODE_MAT   = 4'd9;
    localparam mode_t MODE_LERP  = 4'd10;

    localparam row_t ROW_LAST = 2'd2;

    // Rounding bias, 1.0 in operand format and 1.0 in product format.
    localparam acc_t HALF_ACC  = acc_t'(1) <<< (FB - 1);
    localparam op_t  ONE_OP    = op_t'(1) <<< FB;
    localparam acc_t ONE_PROD  = acc_t'(1) <<< (2 * FB);

    localparam word_t WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DW-1){1'b0}}};

endpackage

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: add, subtract, Hamilton product, scale, negate,
// conjugate, dot, length squared, vector rotation, rotation matrix and lerp.
// Throughput: one word per cycle while m_tready does not hold the output;
// a matrix word gives three result words and holds the pipeline until its
// last row is taken. The rotate path sets the depth.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the row counter; no other state.
module quaternion_arithmetic_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in (32 bits each)
    input  logic [287:0] s_tdata,
    // mode
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_w, res_x, res_y, res_z, scalar_out (32 bits each)
    output logic [159:0] m_tdata,
    // row_index (2 bits), saturated
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import qau_pkg::*;

    logic en;

    // Stage 1: input registers.
    logic  s1_valid_reg;
    mode_t s1_mode_reg;
    word_t s1_a_reg [4];
    word_t s1_b_reg [4];
    word_t s1_s_reg;

    // Stage 2: products.
    logic  s2_valid_reg;
    mode_t s2_mode_reg;
    prod_t s2_p_reg [NPROD];
    word_t s2_a_reg [4];
    word_t s2_b_reg [4];

    // Stage 3: sums.
    logic  s3_valid_reg;
    mode_t s3_mode_reg;
    acc_t  s3_c_reg [NLANE];
    logic  s3_rnd_reg;
    word_t s3_a_reg [4];
    word_t s3_b_reg [4];

    // Stage 4: rounded lanes.
    logic  s4_valid_reg;
    mode_t s4_mode_reg;
    word_t s4_r_reg [NLANE];
    logic  s4_sat_reg [NLANE];
    word_t s4_a_reg [4];
    word_t s4_b_reg [4];

    // Stage 5: second rotate products.
    logic  s5_valid_reg;
    mode_t s5_mode_reg;
    word_t s5_r_reg [NLANE];
    logic  s5_sat_reg [NLANE];
    prod_t s5_q_reg [6];
    word_t s5_b_reg [4];

    // Stage 6: rotate sums.
    logic  s6_valid_reg;
    mode_t s6_mode_reg;
    word_t s6_r_reg [NLANE];
    logic  s6_sat_reg [NLANE];
    acc_t  s6_v_reg [3];

    // Output register.
    logic  out_valid_reg;
    mode_t out_mode_reg;
    word_t out_r_reg [NLANE];
    logic  out_sat_reg;
    logic  out_rsat_reg [3];
    row_t  row_reg;

    logic  last_row;

    // The whole pipeline moves when the output is free or gives its last row.
    always_comb
    begin
        last_row = (out_mode_reg != MODE_MAT) || (row_reg == ROW_LAST);
        en       = !out_valid_reg || (m_tready && last_row);
    end
    assign s_tready = en;

    // Valid bits, row counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else if (en)
        begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
            row_reg       <= '0;
        end
        else if (m_tready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    // Stage 1 capture.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg <= s_tuser;
            for (int i = 0; i < 4; i++)
            begin
                s1_a_reg[i] <= s_tdata[DW*i +: DW];
                s1_b_reg[i] <= s_tdata[DW*(4+i) +: DW];
            end
            s1_s_reg <= s_tdata[DW*8 +: DW];
        end
    end

    // Stage 2: operand selection for the sixteen multipliers.
    op_t   ox [NPROD];
    op_t   oy [NPROD];
    op_t   dir [4];
    op_t   omt;
    logic  dir_mode;
    prod_t p_next [NPROD];

    always_comb
    begin
        for (int k = 0; k < NPROD; k++)
        begin
            ox[k] = '0;
            oy[k] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            dir[i] = '0;
        end
        dir_mode = 1'b0;
        omt      = ONE_OP - OP_W'(s1_s_reg);
        case (s1_mode_reg)
            MODE_ADD:
            begin
                dir_mode = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    dir[i] = OP_W'(s1_a_reg[i]) + OP_W'(s1_b_reg[i]);
                end
            end
            MODE_SUB:
            begin
                dir_mode = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    dir[i] = OP_W'(s1_a_reg[i]) - OP_W'(s1_b_reg[i]);
                end
            end
            MODE_NEG:
            begin
                dir_mode = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    dir[i] = -OP_W'(s1_a_reg[i]);
                end
            end
            MODE_CONJ:
            begin
                dir_mode = 1'b1;
                dir[0]   = OP_W'(s1_a_reg[0]);
                for (int i = 1; i < 4; i++)
                begin
                    dir[i] = -OP_W'(s1_a_reg[i]);
                end
            end
            MODE_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        ox[i*4+j] = OP_W'(s1_a_reg[i]);
                        oy[i*4+j] = OP_W'(s1_b_reg[j]);
                    end
                end
            end
            MODE_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ox[i] = OP_W'(s1_a_reg[i]);
                    oy[i] = OP_W'(s1_s_reg);
                end
            end
            MODE_DOT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ox[i] = OP_W'(s1_a_reg[i]);
                    oy[i] = OP_W'(s1_b_reg[i]);
                end
            end
            MODE_LENSQ:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ox[i] = OP_W'(s1_a_reg[i]);
                    oy[i] = OP_W'(s1_a_reg[i]);
                end
            end
            MODE_ROT:
            begin
                // t = r x v + w v
                ox[0] = OP_W'(s1_a_reg[2]); oy[0] = OP_W'(s1_b_reg[3]);
                ox[1] = OP_W'(s1_a_reg[3]); oy[1] = OP_W'(s1_b_reg[2]);
                ox[2] = OP_W'(s1_a_reg[0]); oy[2] = OP_W'(s1_b_reg[1]);
                ox[3] = OP_W'(s1_a_reg[3]); oy[3] = OP_W'(s1_b_reg[1]);
                ox[4] = OP_W'(s1_a_reg[1]); oy[4] = OP_W'(s1_b_reg[3]);
                ox[5] = OP_W'(s1_a_reg[0]); oy[5] = OP_W'(s1_b_reg[2]);
                ox[6] = OP_W'(s1_a_reg[1]); oy[6] = OP_W'(s1_b_reg[2]);
                ox[7] = OP_W'(s1_a_reg[2]); oy[7] = OP_W'(s1_b_reg[1]);
                ox[8] = OP_W'(s1_a_reg[0]); oy[8] = OP_W'(s1_b_reg[3]);
            end
            MODE_MAT:
            begin
                // xx yy zz xy xz yz wx wy wz
                ox[0] = OP_W'(s1_a_reg[1]); oy[0] = OP_W'(s1_a_reg[1]);
                ox[1] = OP_W'(s1_a_reg[2]); oy[1] = OP_W'(s1_a_reg[2]);
                ox[2] = OP_W'(s1_a_reg[3]); oy[2] = OP_W'(s1_a_reg[3]);
                ox[3] = OP_W'(s1_a_reg[1]); oy[3] = OP_W'(s1_a_reg[2]);
                ox[4] = OP_W'(s1_a_reg[1]); oy[4] = OP_W'(s1_a_reg[3]);
                ox[5] = OP_W'(s1_a_reg[2]); oy[5] = OP_W'(s1_a_reg[3]);
                ox[6] = OP_W'(s1_a_reg[0]); oy[6] = OP_W'(s1_a_reg[1]);
                ox[7] = OP_W'(s1_a_reg[0]); oy[7] = OP_W'(s1_a_reg[2]);
                ox[8] = OP_W'(s1_a_reg[0]); oy[8] = OP_W'(s1_a_reg[3]);
            end
            MODE_LERP:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ox[i]   = OP_W'(s1_a_reg[i]);
                    oy[i]   = omt;
                    ox[4+i] = OP_W'(s1_b_reg[i]);
                    oy[4+i] = OP_W'(s1_s_reg);
                end
            end
            default:
            begin
                dir_mode = 1'b0;
            end
        endcase
        for (int k = 0; k < NPROD; k++)
        begin
            if (dir_mode && (k < 4))
            begin
                p_next[k] = P_W'(dir[k]);
            end
            else
            begin
                p_next[k] = P_W'(ox[k]) * P_W'(oy[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            for (int k = 0; k < NPROD; k++)
            begin
                s2_p_reg[k] <= p_next[k];
            end
        end
    end

    // Stage 3: combine products into up to nine lanes.
    acc_t pe [NPROD];
    acc_t c_next [NLANE];
    logic rnd_next;

    always_comb
    begin
        for (int k = 0; k < NPROD; k++)
        begin
            pe[k] = ACC_W'(s2_p_reg[k]);
        end
        for (int l = 0; l < NLANE; l++)
        begin
            c_next[l] = '0;
        end
        rnd_next = 1'b1;
        case (s2_mode_reg)
            MODE_ADD, MODE_SUB, MODE_NEG, MODE_CONJ:
            begin
                rnd_next = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    c_next[i] = pe[i];
                end
            end
            MODE_MUL:
            begin
                c_next[0] = pe[0] - pe[5] - pe[10] - pe[15];
                c_next[1] = pe[1] + pe[4] + pe[11] - pe[14];
                c_next[2] = pe[2] - pe[7] + pe[8] + pe[13];
                c_next[3] = pe[3] + pe[6] - pe[9] + pe[12];
            end
            MODE_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    c_next[i] = pe[i];
                end
            end
            MODE_DOT, MODE_LENSQ:
            begin
                c_next[0] = pe[0] + pe[1] + pe[2] + pe[3];
            end
            MODE_ROT:
            begin
                c_next[0] = pe[0] - pe[1] + pe[2];
                c_next[1] = pe[3] - pe[4] + pe[5];
                c_next[2] = pe[6] - pe[7] + pe[8];
            end
            MODE_MAT:
            begin
                c_next[0] = ONE_PROD - ((pe[1] + pe[2]) <<< 1);
                c_next[1] = (pe[3] - pe[8]) <<< 1;
                c_next[2] = (pe[4] + pe[7]) <<< 1;
                c_next[3] = (pe[3] + pe[8]) <<< 1;
                c_next[4] = ONE_PROD - ((pe[0] + pe[2]) <<< 1);
                c_next[5] = (pe[5] - pe[6]) <<< 1;
                c_next[6] = (pe[4] - pe[7]) <<< 1;
                c_next[7] = (pe[5] + pe[6]) <<< 1;
                c_next[8] = ONE_PROD - ((pe[0] + pe[1]) <<< 1);
            end
            MODE_LERP:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    c_next[i] = pe[i] + pe[4+i];
                end
            end
            default:
            begin
                rnd_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_rnd_reg  <= rnd_next;
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_c_reg    <= c_next;
        end
    end

    // Stage 4: round (in the modes that need it) and saturate every lane.
    word_t r_next [NLANE];
    logic  sat_next [NLANE];

    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        qau_rnd_sat u_rnd
        (
            .acc (s3_c_reg[l]),
            .rnd (s3_rnd_reg),
            .val (r_next[l]),
            .sat (sat_next[l])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_mode_reg <= s3_mode_reg;
            s4_a_reg    <= s3_a_reg;
            s4_b_reg    <= s3_b_reg;
            s4_r_reg    <= r_next;
            s4_sat_reg  <= sat_next;
        end
    end

    // Stage 5: r x t products for the rotate path.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_mode_reg <= s4_mode_reg;
            s5_b_reg    <= s4_b_reg;
            s5_r_reg    <= s4_r_reg;
            s5_sat_reg  <= s4_sat_reg;
            s5_q_reg[0] <= P_W'(s4_a_reg[2]) * P_W'(s4_r_reg[2]);
            s5_q_reg[1] <= P_W'(s4_a_reg[3]) * P_W'(s4_r_reg[1]);
            s5_q_reg[2] <= P_W'(s4_a_reg[3]) * P_W'(s4_r_reg[0]);
            s5_q_reg[3] <= P_W'(s4_a_reg[1]) * P_W'(s4_r_reg[2]);
            s5_q_reg[4] <= P_W'(s4_a_reg[1]) * P_W'(s4_r_reg[1]);
            s5_q_reg[5] <= P_W'(s4_a_reg[2]) * P_W'(s4_r_reg[0]);
        end
    end

    // Stage 6: v + 2 (r x t), still in product format.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_mode_reg <= s5_mode_reg;
            s6_r_reg    <= s5_r_reg;
            s6_sat_reg  <= s5_sat_reg;
            for (int i = 0; i < 3; i++)
            begin
                s6_v_reg[i] <= (ACC_W'(s5_b_reg[1+i]) <<< FB)
                    + ((ACC_W'(s5_q_reg[2*i]) - ACC_W'(s5_q_reg[2*i+1])) <<< 1);
            end
        end
    end

    // Stage 7: final rounding of the rotate path, lane merge, row flags.
    word_t rot_val [3];
    logic  rot_sat [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_rot
        qau_rnd_sat u_rnd
        (
            .acc (s6_v_reg[i]),
            .rnd (1'b1),
            .val (rot_val[i]),
            .sat (rot_sat[i])
        );
    end

    word_t fin_r [NLANE];
    logic  fin_sat;
    logic  fin_rsat [3];

    always_comb
    begin
        fin_r   = s6_r_reg;
        fin_sat = 1'b0;
        for (int l = 0; l < NLANE; l++)
        begin
            fin_sat = fin_sat | s6_sat_reg[l];
        end
        for (int r = 0; r < 3; r++)
        begin
            fin_rsat[r] = s6_sat_reg[3*r] | s6_sat_reg[3*r+1] | s6_sat_reg[3*r+2];
        end
        if (s6_mode_reg == MODE_ROT)
        begin
            fin_r[0] = '0;
            for (int i = 0; i < 3; i++)
            begin
                fin_r[1+i] = rot_val[i];
                fin_sat    = fin_sat | rot_sat[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mode_reg <= s6_mode_reg;
            out_r_reg    <= fin_r;
            out_sat_reg  <= fin_sat;
            out_rsat_reg <= fin_rsat;
        end
    end

    // Output word selection by mode and matrix row.
    word_t res_w;
    word_t res_x;
    word_t res_y;
    word_t res_z;
    word_t scalar_out;
    row_t  row_index;
    logic  saturated;

    always_comb
    begin
        res_w      = out_r_reg[0];
        res_x      = out_r_reg[1];
        res_y      = out_r_reg[2];
        res_z      = out_r_reg[3];
        scalar_out = '0;
        row_index  = '0;
        saturated  = out_sat_reg;
        case (out_mode_reg)
            MODE_DOT, MODE_LENSQ:
            begin
                res_w      = '0;
                res_x      = '0;
                res_y      = '0;
                res_z      = '0;
                scalar_out = out_r_reg[0];
            end
            MODE_MAT:
            begin
                res_w     = '0;
                row_index = row_reg;
                case (row_reg)
                    2'd0:
                    begin
                        res_x     = out_r_reg[0];
                        res_y     = out_r_reg[1];
                        res_z     = out_r_reg[2];
                        saturated = out_rsat_reg[0];
                    end
                    2'd1:
                    begin
                        res_x     = out_r_reg[3];
                        res_y     = out_r_reg[4];
                        res_z     = out_r_reg[5];
                        saturated = out_rsat_reg[1];
                    end
                    default:
                    begin
                        res_x     = out_r_reg[6];
                        res_y     = out_r_reg[7];
                        res_z     = out_r_reg[8];
                        saturated = out_rsat_reg[2];
                    end
                endcase
            end
            default:
            begin
                scalar_out = '0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {scalar_out, res_z, res_y, res_x, res_w};
    assign m_tuser  = {saturated, row_index};
    assign m_tlast  = last_row;

endmodule

// ===== rtl/qau_rnd_sat.sv =====
// Round-half-up (when rnd is set) and saturate one accumulator lane down to a word.
// Depends on qau_pkg.
module qau_rnd_sat
(
    input  qau_pkg::acc_t  acc,
    input  logic           rnd,
    output qau_pkg::word_t val,
    output logic           sat
);
    import qau_pkg::*;

    acc_t           biased;
    acc_t           shifted;
    logic [ACC_W-DW:0] hi;

    // Optional rounding shift, then a range check on the upper bits.
    always_comb
    begin
        biased  = acc + HALF_ACC;
        shifted = rnd ? (biased >>> FB) : acc;
        hi      = shifted[ACC_W-1:DW-1];
        if ((&hi) || !(|hi))
        begin
            val = shifted[DW-1:0];
            sat = 1'b0;
        end
        else
        begin
            val = shifted[ACC_W-1] ? WORD_MIN : WORD_MAX;
            sat = 1'b1;
        end
    end

endmodule
